### rtl/banked_memory_map_with_port_latch_macros.svh
// Assertion macros shared by the banked memory map RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef BANKED_MEMORY_MAP_WITH_PORT_LATCH_MACROS_SVH
`define BANKED_MEMORY_MAP_WITH_PORT_LATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BMM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bmm_pkg.sv
// Types and constants of the banked memory map with port latch.
// Used by bmm_map and by the top level; depends on nothing.
`default_nettype none

package bmm_pkg;

   typedef enum logic [2:0] {
      OP_MEM_READ   = 3'd0,
      OP_MEM_WRITE  = 3'd1,
      OP_PORT_READ  = 3'd2,
      OP_PORT_WRITE = 3'd3,
      OP_ROM_LOAD   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      SRC_RAM   = 2'd0,
      SRC_ROM   = 2'd1,
      SRC_EMPTY = 2'd2
   } src_type;

   typedef enum logic [1:0] {
      MODE_LOW_ROM    = 2'd0,
      MODE_HIGH_ROM   = 2'd1,
      MODE_HIGH_EMPTY = 2'd2,
      MODE_NONE       = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      RD_ZERO  = 3'd0,
      RD_RAM   = 3'd1,
      RD_ROM   = 3'd2,
      RD_EMPTY = 3'd3,
      RD_PORT  = 3'd4
   } rd_sel_type;

   typedef struct packed {
      logic    hit;
      src_type kind;
   } map_type;

   localparam logic [15:0] VIDEO_BASE   = 16'hD800;
   localparam logic [15:0] LOW_ROM_TOP  = 16'h3FFF;
   localparam logic [15:0] EMPTY_LOW    = 16'h4000;
   localparam logic [15:0] EMPTY_HIGH   = 16'hBFFF;
   localparam logic [7:0]  EMPTY_BYTE   = 8'hFF;
   localparam logic [7:0]  PORT_C_LOAD  = 8'h06;
   localparam logic [7:0]  PORT_C_BITOP = 8'h07;
   localparam int          BITOP_CLEAR  = 7;

endpackage

`default_nettype wire

### rtl/bmm_map.sv
// Overlay address decode: classifies a memory address as RAM, ROM or empty window.
// Depends on bmm_pkg.
`default_nettype none

module bmm_map (
   input  wire logic [1:0]       mode,
   input  wire logic [15:0]      address,
   output bmm_pkg::map_type      map
);

   always_comb begin
      map.hit  = 1'b0;
      map.kind = bmm_pkg::SRC_RAM;
      unique case (bmm_pkg::mode_type'(mode))
         bmm_pkg::MODE_LOW_ROM: begin
            if (address <= bmm_pkg::LOW_ROM_TOP) begin
               map.hit  = 1'b1;
               map.kind = bmm_pkg::SRC_ROM;
            end
         end
         bmm_pkg::MODE_HIGH_ROM: begin
            if (address >= bmm_pkg::VIDEO_BASE) begin
               map.hit  = 1'b1;
               map.kind = bmm_pkg::SRC_ROM;
            end
         end
         bmm_pkg::MODE_HIGH_EMPTY: begin
            if (address >= bmm_pkg::EMPTY_LOW && address <= bmm_pkg::EMPTY_HIGH) begin
               map.hit  = 1'b1;
               map.kind = bmm_pkg::SRC_EMPTY;
            end else if (address >= bmm_pkg::VIDEO_BASE) begin
               map.hit  = 1'b1;
               map.kind = bmm_pkg::SRC_ROM;
            end
         end
         default: begin
            map.hit  = 1'b0;
            map.kind = bmm_pkg::SRC_RAM;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/banked_memory_map_with_port_latch.sv
// Banked memory map with port latch: top level. Depends on bmm_pkg, bmm_map and
// banked_memory_map_with_port_latch_macros.svh.
//
// Each item on the req_ channel is one bus access: memory read or write, port
// read or write, or a ROM load. Each accepted item gives exactly one item on
// the rsp_ channel, in order.
// All state changes and memory reads are issued in the cycle the item is
// accepted; the RAM, ROM and port latch memories return their data straight
// into the registers of the response stage, which also raise rsp_valid. One
// item per cycle is sustained while rsp_ready stays high; the single read port
// of each memory sets that figure.
// When the receiver stalls, the response stage holds its item and req_ready
// drops until it is taken; the same edge that takes it can accept a new item.
// Reset clears the port C latch, overlay mode, video write count and the valid
// bits of the 256 port latches (unwritten latches read zero). RAM and ROM are
// not cleared and must be written before they are read.
`default_nettype none

`include "banked_memory_map_with_port_latch_macros.svh"

module banked_memory_map_with_port_latch #(
   parameter int ROM_DEPTH = 16384,
   parameter int RAM_DEPTH = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_source,
   output logic             rsp_write_dropped,
   output logic [1:0]       rsp_current_mode,
   output logic [31:0]      rsp_video_writes
);

   localparam int ROM_AW = $clog2(ROM_DEPTH);
   localparam int RAM_AW = $clog2(RAM_DEPTH);

   logic [7:0]  rom_ff [ROM_DEPTH];
   logic [7:0]  ram_ff [RAM_DEPTH];
   logic [7:0]  port_ff [256];
   logic [255:0] port_valid_ff;

   logic [7:0]  rom_rdata_ff;
   logic [7:0]  ram_rdata_ff;
   logic [7:0]  port_rdata_ff;
   logic        port_rvalid_ff;

   logic        rsp_valid_ff;
   bmm_pkg::rd_sel_type sel_ff, sel_in;
   bmm_pkg::src_type    src_ff, src_in;
   logic        dropped_ff, dropped_in;
   logic [7:0]  port_c_ff, port_c_in;
   logic [31:0] video_count_ff, video_count_in;

   logic        accept;
   logic        ram_we, rom_we, port_we;
   logic [7:0]  port_idx;
   bmm_pkg::map_type map;

   assign accept   = req_valid && req_ready;
   assign port_idx = req_address[7:0];

   bmm_map u_map (
      .mode    (port_c_ff[1:0]),
      .address (req_address),
      .map     (map)
   );

   always_comb begin
      ram_we         = 1'b0;
      rom_we         = 1'b0;
      port_we        = 1'b0;
      sel_in         = bmm_pkg::RD_ZERO;
      src_in         = bmm_pkg::SRC_RAM;
      dropped_in     = 1'b0;
      port_c_in      = port_c_ff;
      video_count_in = video_count_ff;
      unique case (bmm_pkg::op_type'(req_opcode))
         bmm_pkg::OP_MEM_READ: begin
            if (map.kind == bmm_pkg::SRC_ROM) begin
               sel_in = bmm_pkg::RD_ROM;
               src_in = bmm_pkg::SRC_ROM;
            end else if (map.kind == bmm_pkg::SRC_EMPTY) begin
               sel_in = bmm_pkg::RD_EMPTY;
               src_in = bmm_pkg::SRC_EMPTY;
            end else begin
               sel_in = bmm_pkg::RD_RAM;
            end
         end
         bmm_pkg::OP_MEM_WRITE: begin
            if (map.hit) begin
               dropped_in = 1'b1;
            end else begin
               ram_we = 1'b1;
               if (req_address >= bmm_pkg::VIDEO_BASE && video_count_ff != '1) begin
                  video_count_in = video_count_ff + 32'd1;
               end
            end
         end
         bmm_pkg::OP_PORT_READ: begin
            sel_in = bmm_pkg::RD_PORT;
         end
         bmm_pkg::OP_PORT_WRITE: begin
            port_we = 1'b1;
            if (port_idx == bmm_pkg::PORT_C_LOAD) begin
               port_c_in = req_data;
            end else if (port_idx == bmm_pkg::PORT_C_BITOP) begin
               if (req_data[bmm_pkg::BITOP_CLEAR]) begin
                  port_c_in = 8'd0;
               end else begin
                  port_c_in[req_data[3:1]] = req_data[0];
               end
            end
         end
         bmm_pkg::OP_ROM_LOAD: begin
            rom_we = 1'b1;
         end
         default: begin
            sel_in = bmm_pkg::RD_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ram_rdata_ff   <= ram_ff[req_address[RAM_AW-1:0]];
         rom_rdata_ff   <= rom_ff[req_address[ROM_AW-1:0]];
         port_rdata_ff  <= port_ff[port_idx];
         port_rvalid_ff <= port_valid_ff[port_idx];
         sel_ff         <= sel_in;
         src_ff         <= src_in;
         dropped_ff     <= dropped_in;
         if (ram_we) begin
            ram_ff[req_address[RAM_AW-1:0]] <= req_data;
         end
         if (rom_we) begin
            rom_ff[req_address[ROM_AW-1:0]] <= req_data;
         end
         if (port_we) begin
            port_ff[port_idx] <= req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         port_valid_ff  <= '0;
         port_c_ff      <= 8'd0;
         video_count_ff <= 32'd0;
      end else begin
         if (accept) begin
            rsp_valid_ff   <= 1'b1;
            port_c_ff      <= port_c_in;
            video_count_ff <= video_count_in;
            if (port_we) begin
               port_valid_ff[port_idx] <= 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      case (sel_ff)
         bmm_pkg::RD_RAM:   rsp_read_data = ram_rdata_ff;
         bmm_pkg::RD_ROM:   rsp_read_data = rom_rdata_ff;
         bmm_pkg::RD_EMPTY: rsp_read_data = bmm_pkg::EMPTY_BYTE;
         bmm_pkg::RD_PORT:  rsp_read_data = port_rvalid_ff ? port_rdata_ff : 8'd0;
         default:           rsp_read_data = 8'd0;
      endcase
   end

   assign rsp_source        = src_ff;
   assign rsp_write_dropped = dropped_ff;
   assign rsp_current_mode  = port_c_ff[1:0];
   assign rsp_video_writes  = video_count_ff;

   `BMM_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff, "accepted item lost")

   `BMM_ASSERT_NEXT(a_dropped_keeps_count, clock, reset,
      accept && bmm_pkg::op_type'(req_opcode) == bmm_pkg::OP_MEM_WRITE && map.hit,
      $stable(video_count_ff) && dropped_ff, "dropped write changed the video count")

   `BMM_ASSERT_NEXT(a_port_c_only_by_port_write, clock, reset,
      accept && bmm_pkg::op_type'(req_opcode) != bmm_pkg::OP_PORT_WRITE,
      $stable(port_c_ff), "port C changed without a port write")

   `BMM_ASSERT_NOW(a_overlay_read_not_dropped, clock, reset,
      rsp_valid_ff && src_ff != bmm_pkg::SRC_RAM, !dropped_ff,
      "overlay read flagged as dropped write")

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for banked_memory_map_with_port_latch: a directed table followed
// by random bus traffic under changing idle and stall patterns. Depends on bmm_pkg and the RTL.

module tb_top;

   localparam int          ROM_WORDS        = 16384;
   localparam int          RAM_WORDS        = 65536;
   localparam int          WATCHDOG_LIMIT   = 5000;
   localparam int          DRAIN_CYCLES     = 4;
   localparam int          RANDOM_PER_PHASE = 150;
   localparam logic [13:0] HIGH_ROM_BASE    = 14'h1800;
   localparam logic [2:0]  OP_RESERVED_LO   = 3'd5;
   localparam logic [2:0]  OP_RESERVED_HI   = 3'd7;

   typedef struct {
      logic [7:0]         read_data;
      bmm_pkg::src_type   source;
      logic               dropped;
      bmm_pkg::mode_type  mode;
      logic [31:0]        video;
   } bus_result_type;

   typedef struct {
      logic [2:0]     opcode;
      logic [15:0]    address;
      logic [7:0]     data;
      bit             known;
      bus_result_type result;
   } bus_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_source;
   logic        rsp_write_dropped;
   logic [1:0]  rsp_current_mode;
   logic [31:0] rsp_video_writes;

   logic [7:0]  rom_image [ROM_WORDS];
   bit          rom_loaded [ROM_WORDS];
   logic [7:0]  ram_image [RAM_WORDS];
   bit          ram_loaded [RAM_WORDS];
   logic [7:0]  port_image [256];
   logic [7:0]  port_c;
   bmm_pkg::mode_type bus_mode;
   logic [31:0] video_count;
   logic [15:0] ram_written [$];
   logic [13:0] rom_written [$];

   bus_result_type expected_q [$];
   bus_result_type want;
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   banked_memory_map_with_port_latch u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_address       (req_address),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_source        (rsp_source),
      .rsp_write_dropped (rsp_write_dropped),
      .rsp_current_mode  (rsp_current_mode),
      .rsp_video_writes  (rsp_video_writes)
   );

   always #6 clock = ~clock;

   function automatic bmm_pkg::src_type map_target(input logic [15:0] a,
                                                   input bmm_pkg::mode_type m,
                                                   output logic [13:0] idx);
      bmm_pkg::src_type hit;
      hit = bmm_pkg::SRC_RAM;
      idx = '0;
      if (m == bmm_pkg::MODE_LOW_ROM) begin
         if (a <= bmm_pkg::LOW_ROM_TOP) begin
            idx = a[13:0];
            hit = bmm_pkg::SRC_ROM;
         end
      end else if (m == bmm_pkg::MODE_HIGH_ROM || m == bmm_pkg::MODE_HIGH_EMPTY) begin
         if (m == bmm_pkg::MODE_HIGH_EMPTY && a >= bmm_pkg::EMPTY_LOW &&
             a <= bmm_pkg::EMPTY_HIGH) begin
            hit = bmm_pkg::SRC_EMPTY;
         end else if (a >= bmm_pkg::VIDEO_BASE) begin
            idx = 14'(HIGH_ROM_BASE + (a - bmm_pkg::VIDEO_BASE));
            hit = bmm_pkg::SRC_ROM;
         end
      end
      return hit;
   endfunction

   function automatic bit readable(input logic [15:0] a);
      logic [13:0]      idx;
      bmm_pkg::src_type hit;
      hit = map_target(a, bus_mode, idx);
      return hit == bmm_pkg::SRC_EMPTY || (hit == bmm_pkg::SRC_ROM && rom_loaded[idx]) ||
             (hit == bmm_pkg::SRC_RAM && ram_loaded[a]);
   endfunction

   function automatic bus_result_type apply_access(input logic [2:0] op,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] data);
      bus_result_type   r;
      logic [13:0]      idx;
      bmm_pkg::src_type hit;
      logic [7:0]       port;
      r.read_data = '0;
      r.source = bmm_pkg::SRC_RAM;
      r.dropped = 1'b0;
      hit = map_target(addr, bus_mode, idx);
      port = addr[7:0];
      case (op)
         bmm_pkg::OP_MEM_READ: begin
            r.source = hit;
            if (hit == bmm_pkg::SRC_ROM) r.read_data = rom_image[idx];
            else if (hit == bmm_pkg::SRC_EMPTY) r.read_data = bmm_pkg::EMPTY_BYTE;
            else r.read_data = ram_image[addr];
         end
         bmm_pkg::OP_MEM_WRITE: begin
            if (hit != bmm_pkg::SRC_RAM) begin
               r.dropped = 1'b1;
            end else begin
               ram_image[addr] = data;
               if (!ram_loaded[addr]) ram_written.push_back(addr);
               ram_loaded[addr] = 1'b1;
               if (addr >= bmm_pkg::VIDEO_BASE && video_count != '1) video_count++;
            end
         end
         bmm_pkg::OP_PORT_READ: r.read_data = port_image[port];
         bmm_pkg::OP_PORT_WRITE: begin
            port_image[port] = data;
            if (port == bmm_pkg::PORT_C_LOAD) begin
               port_c = data;
            end else if (port == bmm_pkg::PORT_C_BITOP) begin
               if (data[bmm_pkg::BITOP_CLEAR]) port_c = '0;
               else port_c[data[3:1]] = data[0];
            end
            bus_mode = bmm_pkg::mode_type'(port_c[1:0]);
         end
         bmm_pkg::OP_ROM_LOAD: begin
            rom_image[addr[13:0]] = data;
            if (!rom_loaded[addr[13:0]]) rom_written.push_back(addr[13:0]);
            rom_loaded[addr[13:0]] = 1'b1;
         end
         default: ;
      endcase
      r.mode = bus_mode;
      r.video = video_count;
      return r;
   endfunction

   function automatic bus_item_type item_of(input logic [2:0] op, input logic [15:0] addr,
                                            input logic [7:0] data);
      bus_item_type it;
      it.opcode = op;
      it.address = addr;
      it.data = data;
      it.known = 1'b0;
      return it;
   endfunction

   function automatic bus_item_type item_with_result(input logic [2:0] op,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] data,
                                                     input logic [7:0] rd,
                                                     input bmm_pkg::src_type src,
                                                     input logic drop,
                                                     input bmm_pkg::mode_type m,
                                                     input logic [31:0] video);
      bus_item_type it;
      it = item_of(op, addr, data);
      it.known = 1'b1;
      it.result.read_data = rd;
      it.result.source = src;
      it.result.dropped = drop;
      it.result.mode = m;
      it.result.video = video;
      return it;
   endfunction

   // Memory reads only go where the current map lands on written bytes or the empty window;
   // otherwise the item turns into a port read.
   task automatic make_random(output logic [2:0] op, output logic [15:0] addr,
                              output logic [7:0] data);
      int          pick;
      int          tries;
      bit          found;
      logic [13:0] idx;
      logic [15:0] cand;
      pick = $urandom_range(99);
      data = 8'($urandom);
      addr = 16'($urandom);
      if (pick < 8) begin
         op = bmm_pkg::OP_ROM_LOAD;
      end else if (pick < 22) begin
         op = bmm_pkg::OP_PORT_WRITE;
         case ($urandom_range(4))
            0, 1: addr[7:0] = bmm_pkg::PORT_C_LOAD;
            2, 3: addr[7:0] = bmm_pkg::PORT_C_BITOP;
            default: ;
         endcase
      end else if (pick < 32) begin
         op = bmm_pkg::OP_PORT_READ;
         if ($urandom_range(1) == 0) begin
            addr[7:0] = ($urandom_range(1) == 0) ? bmm_pkg::PORT_C_LOAD :
                                                   bmm_pkg::PORT_C_BITOP;
         end
      end else if (pick < 58) begin
         op = bmm_pkg::OP_MEM_WRITE;
         if (ram_written.size() > 0 && $urandom_range(9) < 3) begin
            addr = ram_written[$urandom_range(ram_written.size() - 1)];
         end
      end else if (pick < 97) begin
         op = bmm_pkg::OP_PORT_READ;
         found = 1'b0;
         for (tries = 0; tries < 6 && !found; tries++) begin
            cand = 16'($urandom);
            case ($urandom_range(2))
               0: if (ram_written.size() > 0) begin
                  cand = ram_written[$urandom_range(ram_written.size() - 1)];
               end
               1: if (rom_written.size() > 0) begin
                  idx = rom_written[$urandom_range(rom_written.size() - 1)];
                  if (bus_mode == bmm_pkg::MODE_LOW_ROM) cand = {2'b00, idx};
                  else cand = bmm_pkg::VIDEO_BASE + 16'(idx) - 16'(HIGH_ROM_BASE);
               end
               default: ;
            endcase
            if (readable(cand)) begin
               found = 1'b1;
               op = bmm_pkg::OP_MEM_READ;
               addr = cand;
            end
         end
      end else begin
         op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end
   endtask

   task automatic send_item(input bus_item_type it);
      bus_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_address <= it.address;
      req_data <= it.data;
      do @(posedge clock); while (!req_ready);
      predicted = apply_access(it.opcode, it.address, it.data);
      expected_q.push_back(it.known ? it.result : predicted);
   endtask

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report("response item with no request outstanding");
         end else begin
            want = expected_q.pop_front();
            if (rsp_read_data !== want.read_data)
               report($sformatf("read_data %02h, expected %02h", rsp_read_data, want.read_data));
            if (rsp_source !== want.source)
               report($sformatf("source %0d, expected %0d", rsp_source, want.source));
            if (rsp_write_dropped !== want.dropped)
               report($sformatf("write_dropped %0b, expected %0b", rsp_write_dropped,
                                want.dropped));
            if (rsp_current_mode !== want.mode)
               report($sformatf("current_mode %0d, expected %0d", rsp_current_mode, want.mode));
            if (rsp_video_writes !== want.video)
               report($sformatf("video_writes %0d, expected %0d", rsp_video_writes, want.video));
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL banked_memory_map_with_port_latch");
         $finish;
      end
   end

   initial begin
      bus_item_type dir_items [$];
      bus_item_type it;
      logic [2:0]   op;
      logic [15:0]  addr;
      logic [7:0]   data;
      int           idle_by_phase [4];
      int           stall_by_phase [4];
      foreach (port_image[i]) port_image[i] = '0;
      port_c = '0;
      bus_mode = bmm_pkg::MODE_LOW_ROM;
      video_count = '0;
      idle_by_phase = '{0, 83, 0, 24};
      stall_by_phase = '{0, 0, 83, 24};
      dir_items = '{
         item_with_result(bmm_pkg::OP_PORT_READ, 16'h0000, 8'h00, 8'h00, bmm_pkg::SRC_RAM,
                          1'b0, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_with_result(bmm_pkg::OP_PORT_READ, 16'hFFFF, 8'hFF, 8'h00, bmm_pkg::SRC_RAM,
                          1'b0, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_with_result(bmm_pkg::OP_MEM_WRITE, 16'h0000, 8'hFF, 8'h00, bmm_pkg::SRC_RAM,
                          1'b1, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_with_result(bmm_pkg::OP_MEM_WRITE, 16'h3FFF, 8'h00, 8'h00, bmm_pkg::SRC_RAM,
                          1'b1, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_with_result(bmm_pkg::OP_ROM_LOAD, 16'hFFFF, 8'hA5, 8'h00, bmm_pkg::SRC_RAM,
                          1'b0, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_with_result(bmm_pkg::OP_ROM_LOAD, 16'h0000, 8'h5A, 8'h00, bmm_pkg::SRC_RAM,
                          1'b0, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_with_result(bmm_pkg::OP_ROM_LOAD, 16'h5800, 8'h3C, 8'h00, bmm_pkg::SRC_RAM,
                          1'b0, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_with_result(OP_RESERVED_HI, 16'hFFFF, 8'hFF, 8'h00, bmm_pkg::SRC_RAM,
                          1'b0, bmm_pkg::MODE_LOW_ROM, 32'd0),
         item_of(bmm_pkg::OP_MEM_READ, 16'h3FFF, 8'hFF),
         item_of(bmm_pkg::OP_MEM_WRITE, 16'h4000, 8'h11),
         item_of(bmm_pkg::OP_MEM_WRITE, 16'hD800, 8'h22),
         item_of(bmm_pkg::OP_MEM_WRITE, 16'hFFFF, 8'hFF),
         item_of(bmm_pkg::OP_MEM_READ, 16'h4000, 8'h00),
         item_of(bmm_pkg::OP_PORT_WRITE, 16'h0006, 8'h01),
         item_of(bmm_pkg::OP_MEM_READ, 16'hD800, 8'h00),
         item_of(bmm_pkg::OP_MEM_READ, 16'hFFFF, 8'h00),
         item_of(bmm_pkg::OP_MEM_WRITE, 16'hD800, 8'h99),
         item_of(bmm_pkg::OP_PORT_WRITE, 16'h1207, 8'h0F),
         item_of(bmm_pkg::OP_PORT_WRITE, 16'h0007, 8'h03),
         item_of(bmm_pkg::OP_MEM_WRITE, 16'h0000, 8'h77),
         item_of(bmm_pkg::OP_MEM_READ, 16'h0000, 8'h00),
         item_of(bmm_pkg::OP_PORT_WRITE, 16'h0007, 8'h00),
         item_of(bmm_pkg::OP_MEM_READ, 16'h4000, 8'h00),
         item_of(bmm_pkg::OP_MEM_WRITE, 16'hBFFF, 8'h00),
         item_of(bmm_pkg::OP_PORT_WRITE, 16'hFF07, 8'h80),
         item_of(bmm_pkg::OP_PORT_READ, 16'h0007, 8'h00)
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_items[i]) send_item(dir_items[i]);
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         repeat (RANDOM_PER_PHASE) begin
            make_random(op, addr, data);
            it = item_of(op, addr, data);
            send_item(it);
         end
      end
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS banked_memory_map_with_port_latch");
      end else begin
         $display("FAIL banked_memory_map_with_port_latch");
      end
      $finish;
   end

endmodule
